### hw/rtl/fixed_radius_neighbor_query_assert.svh
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_query_assert.svh
// Assertion shorthands for the neighbor query block. The asserting module
// must have signals named clock and reset (synchronous, active high).
// ----------------------------------------------------------------------------
`ifndef FIXED_RADIUS_NEIGHBOR_QUERY_ASSERT_SVH
`define FIXED_RADIUS_NEIGHBOR_QUERY_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FRNQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FRNQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/frnq_pkg.sv
// ----------------------------------------------------------------------------
// frnq_pkg
// Shared types and constants of the fixed-radius neighbor query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frnq_pkg;

   localparam int STORE_DEPTH_DEF   = 1024;
   localparam int GROUP_WIDTH_DEF   = 32;
   localparam int COORD_BITS_DEF    = 24;
   localparam int RADIUS_W          = 50;
   localparam int CMD_W             = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_RESP,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

### hw/rtl/frnq_ram.sv
// ----------------------------------------------------------------------------
// frnq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/frnq_lane.sv
// ----------------------------------------------------------------------------
// frnq_lane
// One distance lane: absolute differences, squares, sum, radius compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frnq_lane #(
   parameter int COORD_BITS = frnq_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           advance,
   input  logic signed [COORD_BITS-1:0]   query_x,
   input  logic signed [COORD_BITS-1:0]   query_y,
   input  logic signed [COORD_BITS-1:0]   query_z,
   input  logic        [COORD_BITS-1:0]   entry_x,
   input  logic        [COORD_BITS-1:0]   entry_y,
   input  logic        [COORD_BITS-1:0]   entry_z,
   input  logic [frnq_pkg::RADIUS_W-1:0]  radius,
   output logic                           hit
);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int SUM_W  = SQ_W + 2;
   localparam int CMP_W  = (SUM_W > frnq_pkg::RADIUS_W) ? SUM_W : frnq_pkg::RADIUS_W;

   logic signed [COORD_BITS-1:0] q_pt [3];
   logic signed [COORD_BITS-1:0] e_pt [3];
   logic signed [DIFF_W-1:0]     diff [3];
   logic        [COORD_BITS-1:0] abs_in [3];
   logic        [COORD_BITS-1:0] abs_ff [3];
   logic        [SQ_W-1:0]       sq_in [3];
   logic        [SQ_W-1:0]       sq_ff [3];
   logic        [SUM_W-1:0]      sum_in;
   logic        [SUM_W-1:0]      sum_ff;

   assign q_pt[0] = query_x;
   assign q_pt[1] = query_y;
   assign q_pt[2] = query_z;
   assign e_pt[0] = $signed(entry_x);
   assign e_pt[1] = $signed(entry_y);
   assign e_pt[2] = $signed(entry_z);

   // |a - b| always fits the coordinate width
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]   = DIFF_W'(q_pt[a]) - DIFF_W'(e_pt[a]);
         abs_in[a] = diff[a][DIFF_W-1] ? COORD_BITS'(-diff[a]) : COORD_BITS'(diff[a]);
         sq_in[a]  = abs_ff[a] * abs_ff[a];
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_ff <= abs_in;
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
      end
   end

   assign hit = CMP_W'(sum_ff) <= CMP_W'(radius);

endmodule

### hw/rtl/frnq_ctrl.sv
// ----------------------------------------------------------------------------
// frnq_ctrl
// Command sequencer: particle count, row read-modify-write for loads, scan
// issue, pipeline tags and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fixed_radius_neighbor_query_assert.svh"

module frnq_ctrl #(
   parameter int STORE_DEPTH   = frnq_pkg::STORE_DEPTH_DEF,
   parameter int GROUP_WIDTH   = frnq_pkg::GROUP_WIDTH_DEF,
   parameter int COORD_BITS    = frnq_pkg::COORD_BITS_DEF,
   localparam int ROWS    = (STORE_DEPTH + GROUP_WIDTH - 1) / GROUP_WIDTH,
   localparam int GIDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int ENTRY_W = 3 * COORD_BITS,
   localparam int ROW_W   = GROUP_WIDTH * ENTRY_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [frnq_pkg::CMD_W-1:0]      req_cmd,
   input  logic signed [COORD_BITS-1:0]    req_pos_x,
   input  logic signed [COORD_BITS-1:0]    req_pos_y,
   input  logic signed [COORD_BITS-1:0]    req_pos_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [GIDX_W-1:0]               rsp_group_index,
   output logic [GROUP_WIDTH-1:0]          rsp_hit_mask,
   output logic                            rsp_last,
   output logic                            rsp_status,
   output frnq_pkg::ram_ctl_type           ram_ctl,
   output logic [GIDX_W-1:0]               ram_wr_addr,
   output logic [ROW_W-1:0]                ram_wr_data,
   output logic [GIDX_W-1:0]               ram_rd_addr,
   input  logic [ROW_W-1:0]                ram_rd_data,
   output logic                            lane_adv,
   output logic signed [COORD_BITS-1:0]    query_x,
   output logic signed [COORD_BITS-1:0]    query_y,
   output logic signed [COORD_BITS-1:0]    query_z,
   input  logic [GROUP_WIDTH-1:0]          lane_hit
);

   localparam int PIPE_N    = 4;
   localparam int LANE_W    = $clog2(GROUP_WIDTH);
   localparam int ROW_CNT_W = $clog2(ROWS + 1);
   localparam int COUNT_W   = $clog2(STORE_DEPTH + 1);

   frnq_pkg::state_type state_ff, state_in;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [LANE_W-1:0]    lane_ff, lane_in;
   logic                 resp_status_ff, resp_status_in;
   logic [GIDX_W-1:0]    issue_row_ff, issue_row_in;
   logic                 issue_done_ff, issue_done_in;

   logic signed [COORD_BITS-1:0] q_x_ff, q_y_ff, q_z_ff;

   logic [PIPE_N-1:0]      pipe_vld_ff;
   logic [PIPE_N-1:0]      pipe_last_ff;
   logic [GIDX_W-1:0]      pipe_row_ff  [PIPE_N];
   logic [GROUP_WIDTH-1:0] pipe_mask_ff [PIPE_N];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GIDX_W-1:0]      rsp_group_index_ff, rsp_group_index_in;
   logic [GROUP_WIDTH-1:0] rsp_hit_mask_ff, rsp_hit_mask_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   adv;
   logic                   full;
   logic [ROW_CNT_W-1:0]   last_row;
   logic                   last_issue;
   logic                   issue_fire;
   logic [GROUP_WIDTH-1:0] issue_mask;

   assign req_stall  = (state_ff != frnq_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign lane_adv   = adv;
   assign full       = (count_ff == COUNT_W'(STORE_DEPTH));
   assign last_row   = (lane_ff != '0) ? row_ff : ROW_CNT_W'(row_ff - 1'b1);
   assign last_issue = (issue_row_ff == GIDX_W'(last_row));
   assign issue_fire = (state_ff == frnq_pkg::ST_SCAN) && adv && !issue_done_ff;

   // Lanes past the particle count in the final row read as misses
   always_comb begin
      for (int i = 0; i < GROUP_WIDTH; i++) begin
         issue_mask[i] = !last_issue || (lane_ff == '0) || (LANE_W'(i) < lane_ff);
      end
   end

   // Merge the new particle into its lane of the row just read
   always_comb begin
      for (int i = 0; i < GROUP_WIDTH; i++) begin
         ram_wr_data[i*ENTRY_W +: ENTRY_W] = (lane_ff == LANE_W'(i)) ?
            {q_z_ff, q_y_ff, q_x_ff} : ram_rd_data[i*ENTRY_W +: ENTRY_W];
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      row_in         = row_ff;
      lane_in        = lane_ff;
      resp_status_in = resp_status_ff;
      issue_row_in   = issue_row_ff;
      issue_done_in  = issue_done_ff;
      ram_ctl.rd_en  = 1'b0;
      ram_ctl.wr_en  = 1'b0;
      ram_rd_addr    = issue_row_ff;
      ram_wr_addr    = GIDX_W'(row_ff);
      unique case (state_ff)
         frnq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (frnq_pkg::cmd_type'(req_cmd))
                  frnq_pkg::CMD_CLEAR: begin
                     count_in       = '0;
                     row_in         = '0;
                     lane_in        = '0;
                     resp_status_in = 1'b0;
                     state_in       = frnq_pkg::ST_RESP;
                  end
                  frnq_pkg::CMD_LOAD: begin
                     if (full) begin
                        resp_status_in = 1'b1;
                        state_in       = frnq_pkg::ST_RESP;
                     end else begin
                        state_in = frnq_pkg::ST_LOAD_RD;
                     end
                  end
                  frnq_pkg::CMD_QUERY: begin
                     resp_status_in = 1'b0;
                     if (count_ff == '0) begin
                        state_in = frnq_pkg::ST_RESP;
                     end else begin
                        issue_row_in  = '0;
                        issue_done_in = 1'b0;
                        state_in      = frnq_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         frnq_pkg::ST_LOAD_RD: begin
            ram_ctl.rd_en = 1'b1;
            ram_rd_addr   = GIDX_W'(row_ff);
            state_in      = frnq_pkg::ST_LOAD_WR;
         end
         frnq_pkg::ST_LOAD_WR: begin
            ram_ctl.wr_en  = 1'b1;
            count_in       = COUNT_W'(count_ff + 1'b1);
            resp_status_in = 1'b0;
            if (lane_ff == LANE_W'(GROUP_WIDTH - 1)) begin
               lane_in = '0;
               row_in  = ROW_CNT_W'(row_ff + 1'b1);
            end else begin
               lane_in = LANE_W'(lane_ff + 1'b1);
            end
            state_in = frnq_pkg::ST_RESP;
         end
         frnq_pkg::ST_RESP: begin
            if (adv) begin
               state_in = frnq_pkg::ST_IDLE;
            end
         end
         frnq_pkg::ST_SCAN: begin
            ram_ctl.rd_en = adv;
            if (issue_fire) begin
               issue_row_in = GIDX_W'(issue_row_ff + 1'b1);
               if (last_issue) begin
                  issue_done_in = 1'b1;
               end
            end
            if (adv && pipe_vld_ff[PIPE_N-1] && pipe_last_ff[PIPE_N-1]) begin
               state_in = frnq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frnq_pkg::ST_IDLE;
         end
      endcase
   end

   // Result register: single answers or one scanned group per transfer
   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_group_index_in = rsp_group_index_ff;
      rsp_hit_mask_in    = rsp_hit_mask_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_status_in      = rsp_status_ff;
      priority if ((state_ff == frnq_pkg::ST_RESP) && adv) begin
         rsp_valid_in       = 1'b1;
         rsp_group_index_in = '0;
         rsp_hit_mask_in    = '0;
         rsp_last_in        = 1'b1;
         rsp_status_in      = resp_status_ff;
      end else if ((state_ff == frnq_pkg::ST_SCAN) && adv && pipe_vld_ff[PIPE_N-1]) begin
         rsp_valid_in       = 1'b1;
         rsp_group_index_in = pipe_row_ff[PIPE_N-1];
         rsp_hit_mask_in    = lane_hit & pipe_mask_ff[PIPE_N-1];
         rsp_last_in        = pipe_last_ff[PIPE_N-1];
         rsp_status_in      = 1'b0;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= frnq_pkg::ST_IDLE;
         count_ff      <= '0;
         row_ff        <= '0;
         lane_ff       <= '0;
         issue_done_ff <= 1'b0;
         pipe_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         row_ff        <= row_in;
         lane_ff       <= lane_in;
         issue_done_ff <= issue_done_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (adv) begin
            pipe_vld_ff <= {pipe_vld_ff[PIPE_N-2:0], issue_fire};
         end
      end
   end

   always_ff @(posedge clock) begin
      resp_status_ff     <= resp_status_in;
      issue_row_ff       <= issue_row_in;
      rsp_group_index_ff <= rsp_group_index_in;
      rsp_hit_mask_ff    <= rsp_hit_mask_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_status_ff      <= rsp_status_in;
      if (accept) begin
         q_x_ff <= req_pos_x;
         q_y_ff <= req_pos_y;
         q_z_ff <= req_pos_z;
      end
      if (adv) begin
         pipe_last_ff    <= {pipe_last_ff[PIPE_N-2:0], last_issue};
         pipe_row_ff[0]  <= issue_row_ff;
         pipe_mask_ff[0] <= issue_mask;
         for (int k = 1; k < PIPE_N; k++) begin
            pipe_row_ff[k]  <= pipe_row_ff[k-1];
            pipe_mask_ff[k] <= pipe_mask_ff[k-1];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group_index = rsp_group_index_ff;
   assign rsp_hit_mask    = rsp_hit_mask_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;
   assign query_x         = q_x_ff;
   assign query_y         = q_y_ff;
   assign query_z         = q_z_ff;

   `FRNQ_ASSERT_SAME(a_load_rmw, ram_ctl.wr_en,
      $past(ram_ctl.rd_en) && !full, "row write without fresh read or into full store")
   `FRNQ_ASSERT_NEXT(a_scan_count_hold, state_ff == frnq_pkg::ST_SCAN,
      $stable(count_ff), "particle count moved during a scan")
   `FRNQ_ASSERT_NEXT(a_scan_drain,
      (state_ff == frnq_pkg::ST_SCAN) && adv && pipe_vld_ff[PIPE_N-1] && pipe_last_ff[PIPE_N-1],
      (state_ff == frnq_pkg::ST_IDLE) && (pipe_vld_ff == '0), "scan ended with groups in flight")
   `FRNQ_ASSERT_SAME(a_issue_bound, issue_fire,
      issue_row_ff <= GIDX_W'(last_row), "scan issued a row past the last group")

endmodule

### hw/rtl/fixed_radius_neighbor_query.sv
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_query
// Fixed-radius neighbor query over a stored particle set. Each request
// carries a command: clear empties the store, load appends one position
// (signed Q12.12 x, y, z) and answers with status 1 and nothing stored when
// the store already holds STORE_DEPTH particles, query tests every stored
// particle with dx*dx + dy*dy + dz*dz <= the squared radius in exact fixed
// point and returns one hit mask per group of GROUP_WIDTH particles, in group
// order, with last set on the final group (an empty store gives one all-zero
// mask). Clear and load return a single zero mask with last set; command
// code 3 is ignored and returns nothing. The squared radius (Q26.24) is
// written through csr_wr_en / csr_wr_data; the user must do so only while
// the block is idle, which the block itself does not enforce. Positions
// live in one RAM whose row holds a whole group, so a query reads one row per
// cycle while the result side does not stall, and GROUP_WIDTH distance lanes
// work on it in parallel. A row passes the registered RAM read, the difference,
// square and sum stages and the result register. A load is a read-modify-write
// of its row: it reads the row, writes it back with the new particle merged
// into its lane, then answers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_radius_neighbor_query #(
   parameter int STORE_DEPTH   = frnq_pkg::STORE_DEPTH_DEF,
   parameter int GROUP_WIDTH   = frnq_pkg::GROUP_WIDTH_DEF,
   parameter int COORD_BITS    = frnq_pkg::COORD_BITS_DEF,
   localparam int ROWS    = (STORE_DEPTH + GROUP_WIDTH - 1) / GROUP_WIDTH,
   localparam int GIDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int ENTRY_W = 3 * COORD_BITS,
   localparam int ROW_W   = GROUP_WIDTH * ENTRY_W
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [frnq_pkg::CMD_W-1:0]      req_cmd,
   input  logic signed [COORD_BITS-1:0]    req_pos_x,
   input  logic signed [COORD_BITS-1:0]    req_pos_y,
   input  logic signed [COORD_BITS-1:0]    req_pos_z,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [GIDX_W-1:0]               rsp_group_index,
   output logic [GROUP_WIDTH-1:0]          rsp_hit_mask,
   output logic                            rsp_last,
   output logic                            rsp_status,
   // radius register
   input  logic                            csr_wr_en,
   input  logic [frnq_pkg::RADIUS_W-1:0]   csr_wr_data
);

   logic [frnq_pkg::RADIUS_W-1:0] radius_ff;

   frnq_pkg::ram_ctl_type         ram_ctl;
   logic [GIDX_W-1:0]             ram_wr_addr;
   logic [ROW_W-1:0]              ram_wr_data;
   logic [GIDX_W-1:0]             ram_rd_addr;
   logic [ROW_W-1:0]              ram_rd_data;

   logic                          lane_adv;
   logic signed [COORD_BITS-1:0]  query_x;
   logic signed [COORD_BITS-1:0]  query_y;
   logic signed [COORD_BITS-1:0]  query_z;
   logic [GROUP_WIDTH-1:0]        lane_hit;

   // Squared radius: load on every write, clear to zero at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // Sequencer: decodes commands, owns the count, drives the RAM and the
   // result register. Scans hold whenever the result register cannot drain.
   frnq_ctrl #(
      .STORE_DEPTH   (STORE_DEPTH),
      .GROUP_WIDTH   (GROUP_WIDTH),
      .COORD_BITS    (COORD_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_group_index (rsp_group_index),
      .rsp_hit_mask    (rsp_hit_mask),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .ram_ctl         (ram_ctl),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .lane_adv        (lane_adv),
      .query_x         (query_x),
      .query_y         (query_y),
      .query_z         (query_z),
      .lane_hit        (lane_hit)
   );

   // Particle store: one row per group, lane i at bits [i*ENTRY_W +: ENTRY_W]
   // holding {z, y, x}. Rows never written read as garbage but are only
   // ever scanned in lanes below the particle count.
   frnq_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // One distance lane per particle of a row
   for (genvar g = 0; g < GROUP_WIDTH; g++) begin : g_lane
      frnq_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock   (clock),
         .advance (lane_adv),
         .query_x (query_x),
         .query_y (query_y),
         .query_z (query_z),
         .entry_x (ram_rd_data[g*ENTRY_W +: COORD_BITS]),
         .entry_y (ram_rd_data[g*ENTRY_W + COORD_BITS +: COORD_BITS]),
         .entry_z (ram_rd_data[g*ENTRY_W + 2*COORD_BITS +: COORD_BITS]),
         .radius  (radius_ff),
         .hit     (lane_hit[g])
      );
   end

endmodule
